@@ src/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared codes for the substring search table: request ops, result kinds,
// scan states and the reject characters.
// ----------------------------------------------------------------------------
package sst_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ENTRY = 2'd1,
		OP_PAT   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_MATCH = 2'd0,
		KIND_TOTAL = 2'd1,
		KIND_ACK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_HASH = 8'h23;

endpackage

@@ src/substring_search_table_unit.sv @@
// ----------------------------------------------------------------------------
// substring_search_table_unit
// Table of short strings in one synchronous RAM, searched for a substring.
// ----------------------------------------------------------------------------
// Clear and entry requests are handled in the idle state; an ack leaves the output
// register the cycle after acceptance.
// A search scans one table slot per cycle through the RAM read port, while the
// output is not stalled; the total follows the last slot.
// arst_n clears control state and counts; RAM, character buffers and result
// payload are not reset. No clearing pass: only slots below the count are read.
module substring_search_table_unit #(
	parameter int MAX_ENTRIES  = 65536,
	parameter int ENTRY_LEN    = 16,
	parameter int SEARCH_LIMIT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  ch,
	input  logic        last,
	input  logic [7:0]  max_wanted,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] entry_index,
	output logic [63:0] text_first,
	output logic [55:0] text_second,
	output logic [16:0] found_count,
	output logic [16:0] loaded,
	output logic        done_res
);

	// characters kept per entry and pattern
	localparam int KEEP = ENTRY_LEN - 1;
	localparam int TW   = KEEP * 8;
	localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int LW   = $clog2(ENTRY_LEN);

	sst_pkg::state_t state_q;

	// assembly state
	logic [7:0]    ebuf_q [KEEP];
	logic [LW-1:0] elen_q;
	logic          tl_q;
	logic [7:0]    pbuf_q [KEEP];
	logic [LW-1:0] plen_q;
	logic [LW-1:0] slen_q;   // pattern length held for the scan
	logic [CW-1:0] count_q;

	// scan state
	logic [CW-1:0] next_q;
	logic [CW-1:0] found_q;
	logic [7:0]    cap_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;

	// table RAM
	logic [TW-1:0] mem [MAX_ENTRIES];
	logic [TW-1:0] rdata_q;

	logic          adv;
	logic          accept;
	logic [7:0]    uc;
	logic          e_add;
	logic          p_add;
	logic [LW-1:0] e_newlen;
	logic [LW-1:0] p_newlen;
	logic          tl_new;
	logic [7:0]    first_ch;
	logic          store;
	logic [TW-1:0] wword;
	logic          hit;
	logic          issue;
	logic          emit;
	logic          res_set;
	logic [119:0]  pad;

	assign adv      = !out_valid || out_ready;
	assign in_ready = (state_q == sst_pkg::ST_IDLE) && adv;
	assign accept   = in_valid && in_ready;

	// upper-case a..z only
	assign uc = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'd32 : ch;

	always_comb begin
		e_add    = (uc != 8'd0) && (32'(elen_q) < 32'(KEEP));
		p_add    = (uc != 8'd0) && (32'(plen_q) < 32'(KEEP));
		e_newlen = e_add ? elen_q + 1'b1 : elen_q;
		p_newlen = p_add ? plen_q + 1'b1 : plen_q;
		tl_new   = tl_q || ((uc != 8'd0) && !e_add);
		first_ch = (elen_q == '0) ? uc : ebuf_q[0];
		store    = (e_newlen != '0) && !tl_new && first_ch != sst_pkg::CH_BANG
			&& first_ch != sst_pkg::CH_HASH && (32'(count_q) < 32'(MAX_ENTRIES));
		// packed entry, zero beyond its length
		for (int k = 0; k < KEEP; k++) begin
			if (32'(elen_q) > k)
				wword[k*8 +: 8] = ebuf_q[k];
			else if (e_add && 32'(elen_q) == k)
				wword[k*8 +: 8] = uc;
			else
				wword[k*8 +: 8] = 8'd0;
		end
	end

	// substring compare of the read slot against the held pattern;
	// zero padding never equals a pattern character
	always_comb begin
		logic ok;
		hit = 1'b0;
		for (int s = 0; s < KEEP; s++) begin
			ok = 1'b1;
			for (int j = 0; j < KEEP; j++) begin
				if (32'(slen_q) > j) begin
					if (s + j >= KEEP)
						ok = 1'b0;
					else if (rdata_q[(s+j)*8 +: 8] != pbuf_q[j])
						ok = 1'b0;
				end
			end
			hit = hit | ok;
		end
	end

	assign issue = (state_q == sst_pkg::ST_SCAN) && adv && (next_q != count_q);
	assign emit  = v_s1 && hit && (32'(found_q) < 32'(cap_q));
	assign pad   = 120'(rdata_q);

	// a result is loaded: ack, empty-pattern total, match, or end-of-scan total
	assign res_set = (accept && (op == sst_pkg::OP_CLEAR
			|| (op == sst_pkg::OP_ENTRY && last)
			|| (op == sst_pkg::OP_PAT && last && p_newlen == '0)))
		|| ((state_q == sst_pkg::ST_SCAN) && adv && (emit || (!v_s1 && !issue)));

	// RAM write on entry store, read one slot per advancing scan cycle
	always_ff @(posedge clk) begin
		if (accept && op == sst_pkg::OP_ENTRY && last && store)
			mem[count_q[AW-1:0]] <= wword;
		if (issue)
			rdata_q <= mem[next_q[AW-1:0]];
	end

	// character buffers, no reset
	always_ff @(posedge clk) begin
		for (int k = 0; k < KEEP; k++) begin
			if (accept && op == sst_pkg::OP_ENTRY && e_add && 32'(elen_q) == k)
				ebuf_q[k] <= uc;
			if (accept && op == sst_pkg::OP_PAT && p_add && 32'(plen_q) == k)
				pbuf_q[k] <= uc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sst_pkg::ST_IDLE;
			elen_q    <= '0;
			tl_q      <= 1'b0;
			plen_q    <= '0;
			slen_q    <= '0;
			count_q   <= '0;
			next_q    <= '0;
			found_q   <= '0;
			cap_q     <= '0;
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (res_set)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (state_q)
				sst_pkg::ST_IDLE: begin
					if (accept) begin
						case (op)
							sst_pkg::OP_CLEAR: begin
								count_q <= '0;
								elen_q  <= '0;
								tl_q    <= 1'b0;
								plen_q  <= '0;
							end
							sst_pkg::OP_ENTRY: begin
								elen_q <= last ? '0 : e_newlen;
								tl_q   <= last ? 1'b0 : tl_new;
								if (last && store)
									count_q <= count_q + 1'b1;
							end
							sst_pkg::OP_PAT: begin
								plen_q <= last ? '0 : p_newlen;
								if (last) begin
									slen_q  <= p_newlen;
									found_q <= '0;
									next_q  <= '0;
									cap_q   <= (max_wanted < 8'(SEARCH_LIMIT)) ?
										max_wanted : 8'(SEARCH_LIMIT);
									if (p_newlen != '0)
										state_q <= sst_pkg::ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				sst_pkg::ST_SCAN: begin
					if (adv) begin
						v_s1 <= issue;
						if (issue)
							next_q <= next_q + 1'b1;
						if (v_s1 && hit)
							found_q <= found_q + 1'b1;
						if (!emit && !v_s1 && !issue)
							state_q <= sst_pkg::ST_IDLE;
					end
				end
				default: state_q <= sst_pkg::ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind        <= (op == sst_pkg::OP_PAT) ? sst_pkg::KIND_TOTAL : sst_pkg::KIND_ACK;
			entry_index <= '0;
			text_first  <= '0;
			text_second <= '0;
			found_count <= '0;
			done_res    <= 1'b1;
			if (op == sst_pkg::OP_CLEAR)
				loaded <= '0;
			else if (op == sst_pkg::OP_ENTRY && store)
				loaded <= 17'(count_q + 1'b1);
			else
				loaded <= 17'(count_q);
		end else if (state_q == sst_pkg::ST_SCAN && adv) begin
			loaded      <= 17'(count_q);
			if (emit) begin
				kind        <= sst_pkg::KIND_MATCH;
				entry_index <= 16'(idx_s1);
				text_first  <= pad[63:0];
				text_second <= pad[119:64];
				found_count <= '0;
				done_res    <= 1'b0;
			end else begin
				kind        <= sst_pkg::KIND_TOTAL;
				entry_index <= '0;
				text_first  <= '0;
				text_second <= '0;
				found_count <= 17'(found_q + CW'(v_s1 && hit));
				done_res    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue)
			idx_s1 <= next_q[AW-1:0];
	end

endmodule

@@ src/sst_checker.sv @@
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [15:0] entry_index,
	input logic [63:0] text_first,
	input logic [16:0] found_count,
	input logic        done_res
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(done_res))
		else $error("result dropped while stalled");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (done_res == (kind != sst_pkg::KIND_MATCH)))
		else $error("done flag does not match result kind");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != sst_pkg::KIND_MATCH |-> entry_index == 16'd0
			&& text_first == 64'd0)
		else $error("non-match result carries entry data");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != sst_pkg::KIND_TOTAL |-> found_count == 17'd0)
		else $error("found count outside a total");

endmodule

bind substring_search_table_unit sst_checker u_sst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kind        (kind),
	.entry_index (entry_index),
	.text_first  (text_first),
	.found_count (found_count),
	.done_res    (done_res)
);

@@ sim/substring_search_table_unit_test.sv @@
// ----------------------------------------------------------------------------
// substring_search_table_unit_test
// Self-checking bench for the substring search table: directed table of
// requests, then random entry loads and searches, predicted in-bench and
// compared field by field against the block's results.
// ----------------------------------------------------------------------------
module substring_search_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRY_LEN    = 16;
	localparam int SEARCH_LIMIT = 16;
	localparam int MAX_SLOTS    = 65536;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  ch;
	logic        last;
	logic [7:0]  max_wanted;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [15:0] entry_index;
	logic [63:0] text_first;
	logic [55:0] text_second;
	logic [16:0] found_count;
	logic [16:0] loaded;
	logic        done_res;

	substring_search_table_unit i_dut (.*);

	// one result as the block should present it
	typedef struct {
		sst_pkg::kind_t kind;
		logic [15:0]    idx;
		logic [63:0]    t1;
		logic [55:0]    t2;
		logic [16:0]    found;
		logic [16:0]    loaded;
		logic           done;
	} result_t;

	typedef struct {
		sst_pkg::op_t op;
		logic [7:0]   ch;
		logic         last;
		logic [7:0]   want;
	} request_t;

	result_t pending_results[$];
	int      error_count = 0;
	int      result_count = 0;
	int      search_count = 0;
	int      match_count = 0;
	longint  cycle_count = 0;
	bit      hold_off = 0;
	bit      stalled_once = 0;
	bit      no_idle = 0;

	// predictor state
	logic [63:0] tbl_lo [int];
	logic [55:0] tbl_hi [int];
	int          n_loaded;
	logic [7:0]  ebuf [16];
	int          elen;
	bit          etoo_long;
	logic [7:0]  pbuf [15];
	int          plen;

	function automatic logic [7:0] upper(logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function automatic result_t mk(sst_pkg::kind_t k, logic [15:0] i, logic [63:0] a,
			logic [55:0] b, logic [16:0] f, logic d);
		result_t r;
		r.kind = k; r.idx = i; r.t1 = a; r.t2 = b; r.found = f;
		r.loaded = n_loaded[16:0]; r.done = d;
		return r;
	endfunction

	function automatic bit slot_contains(int s);
		logic [7:0] e [15];
		int n;
		bit hit;
		n = 0;
		for (int i = 0; i < 15; i++) begin
			logic [7:0] c;
			c = (i < 8) ? tbl_lo[s][i*8 +: 8] : tbl_hi[s][(i-8)*8 +: 8];
			if (c == 0)
				break;
			e[n++] = c;
		end
		for (int st = 0; st + plen <= n; st++) begin
			hit = 1;
			for (int j = 0; j < plen; j++)
				if (e[st+j] != pbuf[j])
					hit = 0;
			if (hit)
				return 1;
		end
		return 0;
	endfunction

	// advance the predictor by one request and queue its results
	task automatic predict_request(request_t rq);
		logic [7:0] c;
		int cap, found;
		logic [63:0] w0;
		logic [55:0] w1;
		c = upper(rq.ch);
		case (rq.op)
			sst_pkg::OP_CLEAR: begin
				n_loaded = 0; elen = 0; etoo_long = 0; plen = 0;
				pending_results.push_back(mk(sst_pkg::KIND_ACK, 0, 0, 0, 0, 1));
			end
			sst_pkg::OP_ENTRY: begin
				if (c != 0) begin
					if (elen < ENTRY_LEN - 1)
						ebuf[elen++] = c;
					else
						etoo_long = 1;
				end
				if (rq.last) begin
					if (elen > 0 && !etoo_long && ebuf[0] != sst_pkg::CH_BANG &&
							ebuf[0] != sst_pkg::CH_HASH && n_loaded < MAX_SLOTS) begin
						w0 = 0; w1 = 0;
						for (int i = 0; i < elen; i++)
							if (i < 8)
								w0[i*8 +: 8] = ebuf[i];
							else
								w1[(i-8)*8 +: 8] = ebuf[i];
						tbl_lo[n_loaded] = w0;
						tbl_hi[n_loaded] = w1;
						n_loaded++;
					end
					elen = 0; etoo_long = 0;
					pending_results.push_back(mk(sst_pkg::KIND_ACK, 0, 0, 0, 0, 1));
				end
			end
			sst_pkg::OP_PAT: begin
				if (c != 0 && plen < ENTRY_LEN - 1)
					pbuf[plen++] = c;
				if (rq.last) begin
					found = 0;
					search_count++;
					if (plen > 0) begin
						cap = (rq.want < SEARCH_LIMIT) ? rq.want : SEARCH_LIMIT;
						for (int s = 0; s < n_loaded; s++)
							if (slot_contains(s)) begin
								if (found < cap)
									pending_results.push_back(mk(sst_pkg::KIND_MATCH,
										s[15:0], tbl_lo[s], tbl_hi[s], 0, 0));
								found++;
							end
					end
					match_count += found;
					plen = 0;
					pending_results.push_back(mk(sst_pkg::KIND_TOTAL, 0, 0, 0,
						found[16:0], 1));
				end
			end
			default: ;
		endcase
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("substring_search_table_unit verification failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off requested by the sender side
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			out_ready <= no_idle || ($urandom_range(99) >= 9);
		end
	end

	// checker: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_t e;
			result_count++;
			if (pending_results.size() == 0) begin
				$error("unexpected result kind=%0d", kind);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				if (kind != e.kind) begin
					$error("kind exp %0d got %0d", e.kind, kind); error_count++; end
				if (entry_index != e.idx) begin
					$error("entry_index exp %0d got %0d", e.idx, entry_index);
					error_count++; end
				if (text_first != e.t1) begin
					$error("text_first exp %h got %h", e.t1, text_first); error_count++; end
				if (text_second != e.t2) begin
					$error("text_second exp %h got %h", e.t2, text_second);
					error_count++; end
				if (found_count != e.found) begin
					$error("found_count exp %0d got %0d", e.found, found_count);
					error_count++; end
				if (loaded != e.loaded) begin
					$error("loaded exp %0d got %0d", e.loaded, loaded); error_count++; end
				if (done_res != e.done) begin
					$error("done_res exp %0d got %0d", e.done, done_res); error_count++; end
			end
		end
	end

	// hand one request to the block; valid holds until accepted,
	// and drops only for an idle gap
	task automatic send_request(request_t rq);
		if (!no_idle && $urandom_range(99) < 9) begin
			in_valid <= 0;
			@(negedge clk);
			while ($urandom_range(99) < 9)
				@(negedge clk);
		end
		in_valid <= 1;
		op <= rq.op; ch <= rq.ch; last <= rq.last; max_wanted <= rq.want;
		predict_request(rq);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_string(sst_pkg::op_t o, string s, logic [7:0] want);
		request_t rq;
		for (int i = 0; i < s.len(); i++) begin
			rq.op = o; rq.ch = s[i]; rq.last = (i == s.len() - 1); rq.want = want;
			send_request(rq);
		end
	endtask

	function automatic logic [7:0] rand_char();
		case ($urandom_range(9))
			0: return 8'($urandom_range(255));
			1, 2, 3: return "a" + 8'($urandom_range(2));
			default: return "A" + 8'($urandom_range(2));
		endcase
	endfunction

	// directed table: expected ack values are obvious, and the predictor models every request
	request_t directed [] = '{
		'{sst_pkg::OP_PAT,   8'h00, 1'b1, 8'd5},   // empty pattern: total 0
		'{sst_pkg::OP_ENTRY, "a",   1'b0, 8'd0},
		'{sst_pkg::OP_ENTRY, "b",   1'b1, 8'd0},   // stores "AB"
		'{sst_pkg::OP_ENTRY, "!",   1'b0, 8'd0},
		'{sst_pkg::OP_ENTRY, "x",   1'b1, 8'd0},   // bang first: dropped
		'{sst_pkg::OP_ENTRY, "#",   1'b1, 8'd0},   // hash first: dropped
		'{sst_pkg::OP_ENTRY, 8'h00, 1'b1, 8'd0},   // empty entry: dropped
		'{sst_pkg::OP_ENTRY, 8'hff, 1'b0, 8'd0},
		'{sst_pkg::OP_ENTRY, 8'h00, 1'b1, 8'd0},   // zero char adds nothing, last acts
		'{sst_pkg::OP_NONE,  8'hff, 1'b1, 8'hff},  // unused op: ignored
		'{sst_pkg::OP_PAT,   "b",   1'b1, 8'hff},  // match, huge limit clamps
		'{sst_pkg::OP_PAT,   "A",   1'b1, 8'd0},   // limit zero: total only
		'{sst_pkg::OP_PAT,   "z",   1'b1, 8'd1},   // no match
		'{sst_pkg::OP_CLEAR, 8'h00, 1'b0, 8'd0},
		'{sst_pkg::OP_PAT,   "A",   1'b1, 8'd3}    // empty table
	};

	initial begin
		request_t rq;
		int n, len;
		in_valid = 0; op = sst_pkg::OP_CLEAR; ch = 0; last = 0; max_wanted = 0;
		n_loaded = 0; elen = 0; etoo_long = 0; plen = 0;
		@(posedge arst_n);
		@(negedge clk);

		no_idle = 1;
		foreach (directed[i])
			send_request(directed[i]);
		no_idle = 0;
		// overlong entry (16 chars) dropped; 15-char entry kept; overlong pattern
		send_string(sst_pkg::OP_ENTRY, "abcdefghijklmnop", 0);
		send_string(sst_pkg::OP_ENTRY, "abcdefghijklmno", 0);
		send_string(sst_pkg::OP_PAT, "abcdefghijklmnoXY", 8'd2);

		// random: entry loads and searches with small alphabet so matches happen
		n = 0;
		while (n < 40) begin
			if (n >= 10 && !stalled_once) begin
				hold_off = 1;   // receiver stalls long while searches keep coming
				stalled_once = 1;
			end
			if (n >= 20 && n < 30)
				no_idle = 1;
			else
				no_idle = 0;
			case ($urandom_range(19))
				0: begin
					rq.op = ($urandom_range(3) == 0) ? sst_pkg::OP_CLEAR : sst_pkg::OP_NONE;
					rq.ch = 8'($urandom); rq.last = 1'($urandom); rq.want = 8'($urandom);
					send_request(rq); n++;
				end
				1, 2, 3, 4, 5, 6, 7, 8, 9: begin
					len = ($urandom_range(9) == 0) ? $urandom_range(14, 18)
						: $urandom_range(1, 6);
					for (int i = 0; i < len; i++) begin
						rq.op = sst_pkg::OP_ENTRY; rq.ch = rand_char();
						if (i == 0 && $urandom_range(15) == 0)
							rq.ch = $urandom_range(1) ? sst_pkg::CH_BANG : sst_pkg::CH_HASH;
						rq.last = (i == len - 1); rq.want = 8'($urandom);
						send_request(rq); n++;
					end
				end
				default: begin
					len = ($urandom_range(15) == 0) ? $urandom_range(14, 17)
						: $urandom_range(0, 3);
					for (int i = 0; i <= len; i++) begin
						rq.op = sst_pkg::OP_PAT; rq.ch = (i == len) ? 8'h00 : rand_char();
						if (i == len && $urandom_range(1))
							rq.ch = rand_char();
						rq.last = (i == len);
						rq.want = ($urandom_range(4) == 0) ? 8'($urandom)
							: 8'($urandom_range(0, 5));
						send_request(rq); n++;
					end
				end
			endcase
			if (n_loaded > 60) begin
				rq.op = sst_pkg::OP_CLEAR; rq.ch = 0; rq.last = 0; rq.want = 0;
				send_request(rq); n++;
			end
		end
		in_valid <= 0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d searches, %0d matching entries, %0d results checked.",
			search_count, match_count, result_count);
		if (error_count == 0)
			$display("substring_search_table_unit verification clean");
		else
			$display("substring_search_table_unit verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
src/sst_pkg.sv
src/substring_search_table_unit.sv
src/sst_checker.sv
sim/substring_search_table_unit_test.sv
